// ===== rtl/msort_pkg.sv =====
package msort_pkg;

  localparam int MAX_MEMBERS_DEF = 64;
  localparam int HANDLE_W        = 16;
  localparam int TYPE_W          = 4;
  localparam int SIZE_W          = 4;

  // Size class: 0 is 1 byte, 1 is 2 bytes, 2 is 4 bytes, 3 is 8 bytes.
  typedef logic [1:0] size_class_t;

  localparam size_class_t CLASS_TOP = 2'd3;

  typedef enum logic [TYPE_W-1:0] {
    TC_FLOAT  = 4'd0,
    TC_CHAR   = 4'd1,
    TC_BOOL   = 4'd2,
    TC_INT8   = 4'd3,
    TC_INT16  = 4'd4,
    TC_INT32  = 4'd5,
    TC_INT64  = 4'd6,
    TC_INT    = 4'd7,
    TC_STRUCT = 4'd8,
    TC_SUBR   = 4'd9,
    TC_ARRAY  = 4'd10
  } type_code_t;

  typedef struct packed {
    size_class_t           cls;
    logic [HANDLE_W-1:0]   handle;
  } entry_t;

  typedef struct packed {
    logic        ok;
    size_class_t cls;
  } class_lookup_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CHECK,
    ST_ERR
  } state_t;

  function automatic class_lookup_t code_class(input logic [TYPE_W-1:0] code);
    class_lookup_t r;
    r.ok  = 1'b1;
    r.cls = 2'd0;
    case (code)
      TC_FLOAT, TC_INT32, TC_INT:           r.cls = 2'd2;
      TC_CHAR, TC_BOOL, TC_INT8:            r.cls = 2'd0;
      TC_INT16:                             r.cls = 2'd1;
      TC_INT64, TC_STRUCT, TC_SUBR, TC_ARRAY: r.cls = 2'd3;
      default:                              r.ok  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] class_bytes(input size_class_t cls);
    return SIZE_W'(1) << cls;
  endfunction

endpackage

// ===== rtl/msort_store.sv =====
module msort_store #(
  parameter int DEPTH = msort_pkg::MAX_MEMBERS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  msort_pkg::entry_t        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output msort_pkg::entry_t        rd_data
);

  msort_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/member_size_sort.sv =====
// Loads the members of one record, one word per cycle, into a store of
// MAX_MEMBERS entries, then emits the handles sorted by byte size, largest
// first, keeping load order among equal sizes. After the word marked last,
// no input is taken until the run is out: the sort walks the store once per
// size class from 8 bytes down, with one store read and then one compare
// per entry visited, waits out output stalls and stops at its final result.
// A record with an invalid type code yields a single error word instead.
module member_size_sort #(
  parameter int MAX_MEMBERS = msort_pkg::MAX_MEMBERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [msort_pkg::HANDLE_W-1:0] member_handle,
  input  logic [msort_pkg::TYPE_W-1:0]   type_code,
  input  logic                           last_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [msort_pkg::HANDLE_W-1:0] sorted_handle,
  output logic [msort_pkg::SIZE_W-1:0]   size_bytes,
  output logic                           bad_type,
  output logic                           last_out
);

  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);
  localparam int ADDR_W = $clog2(MAX_MEMBERS);

  msort_pkg::state_t        state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [CNT_W-1:0]         emitted, emitted_next;
  logic                     error_seen, error_seen_next;
  msort_pkg::size_class_t   cls, cls_next;

  msort_pkg::class_lookup_t lookup;
  msort_pkg::entry_t        wr_data;
  msort_pkg::entry_t        rd_data;
  logic                     accept;
  logic                     wr_en;
  logic                     rd_en;
  logic                     out_free;
  logic                     match;
  logic                     load_word;
  logic                     load_err;
  logic                     run_last;

  assign in_ready = (state == msort_pkg::ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign lookup   = msort_pkg::code_class(type_code);
  assign wr_en    = accept && lookup.ok && (count < CNT_W'(MAX_MEMBERS));
  assign wr_data  = '{cls: lookup.cls, handle: member_handle};
  assign rd_en    = (state == msort_pkg::ST_READ);
  assign out_free = !out_valid || out_ready;
  assign match    = (rd_data.cls == cls);
  assign run_last = ((emitted + CNT_W'(1)) == count);

  msort_store #(
    .DEPTH(MAX_MEMBERS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[ADDR_W-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    emitted_next    = emitted;
    error_seen_next = error_seen;
    cls_next        = cls;
    load_word       = 1'b0;
    load_err        = 1'b0;
    unique case (state)
      msort_pkg::ST_LOAD: begin
        if (accept) begin
          if (wr_en) begin
            count_next = count + CNT_W'(1);
          end
          if (!lookup.ok) begin
            error_seen_next = 1'b1;
          end
          if (last_in) begin
            idx_next     = '0;
            emitted_next = '0;
            cls_next     = msort_pkg::CLASS_TOP;
            state_next   = (error_seen || !lookup.ok) ? msort_pkg::ST_ERR
                                                      : msort_pkg::ST_READ;
          end
        end
      end
      msort_pkg::ST_READ: begin
        state_next = msort_pkg::ST_CHECK;
      end
      msort_pkg::ST_CHECK: begin
        // A matching entry waits here until the output register has room.
        if (!match || out_free) begin
          load_word = match;
          if (match) begin
            emitted_next = emitted + CNT_W'(1);
          end
          if (match && run_last) begin
            count_next      = '0;
            error_seen_next = 1'b0;
            state_next      = msort_pkg::ST_LOAD;
          end else begin
            state_next = msort_pkg::ST_READ;
            if ((idx + CNT_W'(1)) == count) begin
              idx_next = '0;
              cls_next = cls - 2'd1;
            end else begin
              idx_next = idx + CNT_W'(1);
            end
          end
        end
      end
      msort_pkg::ST_ERR: begin
        if (out_free) begin
          load_err        = 1'b1;
          count_next      = '0;
          error_seen_next = 1'b0;
          state_next      = msort_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = msort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= msort_pkg::ST_LOAD;
      count      <= '0;
      error_seen <= 1'b0;
      idx        <= '0;
      emitted    <= '0;
      cls        <= msort_pkg::CLASS_TOP;
    end else begin
      state      <= state_next;
      count      <= count_next;
      error_seen <= error_seen_next;
      idx        <= idx_next;
      emitted    <= emitted_next;
      cls        <= cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_word || load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_word) begin
      sorted_handle <= rd_data.handle;
      size_bytes    <= msort_pkg::class_bytes(cls);
      bad_type      <= 1'b0;
      last_out      <= run_last;
    end else if (load_err) begin
      sorted_handle <= '0;
      size_bytes    <= '0;
      bad_type      <= 1'b1;
      last_out      <= 1'b1;
    end
  end

endmodule

// ===== rtl/msort_chk.sv =====
module msort_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           last_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [msort_pkg::HANDLE_W-1:0] sorted_handle,
  input logic [msort_pkg::SIZE_W-1:0]   size_bytes,
  input logic                           bad_type,
  input logic                           last_out
);

  // An error word is always a lone, closing word with empty fields.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_type |-> last_out && size_bytes == '0 && sorted_handle == '0)
    else $error("error word malformed");

  a_size_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_type |->
      size_bytes == 4'd1 || size_bytes == 4'd2 || size_bytes == 4'd4 || size_bytes == 4'd8)
    else $error("size_bytes is not a legal size");

  // Once the last member is taken, input stays closed while the run goes out.
  a_load_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_in |=> !in_ready)
    else $error("input taken right after the last member");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(sorted_handle) && $stable(size_bytes) &&
      $stable(bad_type) && $stable(last_out))
    else $error("stalled output word changed");

endmodule

bind member_size_sort msort_chk u_msort_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .last_in      (last_in),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sorted_handle(sorted_handle),
  .size_bytes   (size_bytes),
  .bad_type     (bad_type),
  .last_out     (last_out)
);

// ===== tb/size_sort_board_pkg.sv =====
`timescale 1ns / 1ps

package size_sort_board_pkg;

  import msort_pkg::*;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic                bad;
    logic                last;
  } sorted_word_t;

  // Tracks the record being loaded and the sorted words it must produce.
  class size_sort_board;
    int unsigned         capacity;
    int unsigned         failures;
    logic [HANDLE_W-1:0] rec_handle[$];
    size_class_t         rec_class[$];
    bit                  rec_bad;
    sorted_word_t        sorted_q[$];

    function new(int unsigned cap);
      capacity = cap;
      failures = 0;
      rec_bad  = 0;
    endfunction

    // Returns 0 for a code that names no type.
    function bit class_of_code(input logic [TYPE_W-1:0] code, output size_class_t cls);
      class_of_code = 1'b1;
      cls = 2'd0;
      case (code)
        TC_CHAR, TC_BOOL, TC_INT8:              cls = 2'd0;
        TC_INT16:                               cls = 2'd1;
        TC_FLOAT, TC_INT32, TC_INT:             cls = 2'd2;
        TC_INT64, TC_STRUCT, TC_SUBR, TC_ARRAY: cls = 2'd3;
        default:                                class_of_code = 1'b0;
      endcase
    endfunction

    function void note_member(input logic [HANDLE_W-1:0] handle,
                              input logic [TYPE_W-1:0] code, input logic last);
      size_class_t  cls;
      sorted_word_t w;
      int           n;
      n = 0;
      if (!class_of_code(code, cls)) begin
        rec_bad = 1'b1;
      end else if (rec_handle.size() < capacity) begin
        rec_handle.push_back(handle);
        rec_class.push_back(cls);
      end
      if (!last) return;
      if (rec_bad) begin
        w.handle = '0;
        w.size   = '0;
        w.bad    = 1'b1;
        w.last   = 1'b1;
        sorted_q.push_back(w);
      end else begin
        // One pass per size class, largest first, in load order within a class.
        for (int c = 3; c >= 0; c--) begin
          for (int i = 0; i < rec_handle.size(); i++) begin
            if (rec_class[i] == size_class_t'(c)) begin
              w.handle = rec_handle[i];
              w.size   = SIZE_W'(1) << c;
              w.bad    = 1'b0;
              w.last   = 1'b0;
              sorted_q.push_back(w);
              n++;
            end
          end
        end
        if (n > 0) sorted_q[sorted_q.size() - 1].last = 1'b1;
      end
      rec_handle.delete();
      rec_class.delete();
      rec_bad = 1'b0;
    endfunction

    function void check_word(input logic [HANDLE_W-1:0] handle, input logic [SIZE_W-1:0] size,
                             input logic bad, input logic last);
      sorted_word_t w;
      if (sorted_q.size() == 0) begin
        $error("unexpected word: sorted_handle %h size_bytes %0d bad_type %b last_out %b",
               handle, size, bad, last);
        failures++;
        return;
      end
      w = sorted_q.pop_front();
      if (handle !== w.handle) begin
        $error("sorted_handle: expected %h, got %h", w.handle, handle);
        failures++;
      end
      if (size !== w.size) begin
        $error("size_bytes: expected %0d, got %0d", w.size, size);
        failures++;
      end
      if (bad !== w.bad) begin
        $error("bad_type: expected %b, got %b", w.bad, bad);
        failures++;
      end
      if (last !== w.last) begin
        $error("last_out: expected %b, got %b", w.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import msort_pkg::*;
  import size_sort_board_pkg::*;

  localparam logic [TYPE_W-1:0] TC_BAD_LOW  = 4'd11;
  localparam logic [TYPE_W-1:0] TC_BAD_HIGH = 4'd15;
  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8 * MAX_MEMBERS_DEF + 100;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [HANDLE_W-1:0] member_handle;
  logic [TYPE_W-1:0]   type_code;
  logic                last_in;
  logic                out_valid;
  logic                out_ready;
  logic [HANDLE_W-1:0] sorted_handle;
  logic [SIZE_W-1:0]   size_bytes;
  logic                bad_type;
  logic                last_out;

  // Phase 0: no idling, 1: sender idles and receiver holds off once, 2: receiver stalls, 3: both.
  int unsigned phase;
  int unsigned send_idle_pct;
  int unsigned words_sent;

  size_sort_board board = new(MAX_MEMBERS_DEF);

  member_size_sort uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .member_handle (member_handle),
    .type_code     (type_code),
    .last_in       (last_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sorted_handle (sorted_handle),
    .size_bytes    (size_bytes),
    .bad_type      (bad_type),
    .last_out      (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic send_member(input logic [HANDLE_W-1:0] handle, input logic [TYPE_W-1:0] code,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    member_handle <= handle;
    type_code     <= code;
    last_in       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_member(handle, code, last);
    words_sent++;
  endtask

  task automatic send_record(input int len, input bit broken);
    int               bad_pos;
    logic [TYPE_W-1:0] code;
    bad_pos = broken ? int'($urandom_range(len - 1)) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_pos || (broken && $urandom_range(9) == 0))
        code = TYPE_W'($urandom_range(TC_BAD_HIGH, TC_BAD_LOW));
      else
        code = TYPE_W'($urandom_range(TC_ARRAY, TC_FLOAT));
      send_member(HANDLE_W'($urandom), code, i == len - 1);
    end
  endtask

  // Receiver: checks each accepted word and chooses out_ready for the next edge.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_pct;
    hold_left = 0;
    hold_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        board.check_word(sorted_handle, size_bytes, bad_type, last_out);
      stall_pct = (phase == 2) ? 65 : (phase == 3) ? 17 : 0;
      if (phase == 1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned goal;
    int          len;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    member_handle <= '0;
    type_code     <= '0;
    last_in       <= 1'b0;
    phase         <= 0;
    send_idle_pct = 0;
    words_sent    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A single member makes a record of its own.
    send_member(16'h0000, TC_FLOAT, 1'b1);
    // Every type code once, handles alternating between the extremes.
    for (int c = 0; c <= 10; c++)
      send_member(c[0] ? 16'hFFFF - HANDLE_W'(c) : HANDLE_W'(c), TYPE_W'(c), c == 10);
    // An invalid code in the middle of a record turns it into one error word.
    send_member(16'h1234, TC_INT8, 1'b0);
    send_member(16'h5678, TC_BAD_LOW, 1'b0);
    send_member(16'h9ABC, TC_INT64, 1'b1);
    // An invalid code on the last member alone.
    send_member(16'hFFFF, TC_BAD_HIGH, 1'b1);
    // The error state must be gone for the next record.
    send_member(16'h8000, TC_INT16, 1'b0);
    send_member(16'h0001, TC_BOOL, 1'b0);
    send_member(16'h7FFF, TC_STRUCT, 1'b1);
    // Equal sizes must keep load order.
    send_member(16'h00A0, TC_SUBR, 1'b0);
    send_member(16'h00B0, TC_INT32, 1'b0);
    send_member(16'h00C0, TC_ARRAY, 1'b0);
    send_member(16'h00D0, TC_FLOAT, 1'b1);

    goal = words_sent;
    for (int p = 0; p < 4; p++) begin
      phase <= p;
      send_idle_pct = (p == 1) ? 65 : (p == 3) ? 17 : 0;
      // A record at least as long as the store: any excess members are dropped.
      if (p == 2) send_record($urandom_range(70, MAX_MEMBERS_DEF), 1'b0);
      goal += RANDOM_ITEMS / 4;
      while (words_sent < goal) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
        send_record(len, $urandom_range(5) == 0);
      end
    end
    in_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== member_size_sort.f =====
rtl/msort_pkg.sv
rtl/msort_store.sv
rtl/member_size_sort.sv
rtl/msort_chk.sv
tb/size_sort_board_pkg.sv
tb/tb_top.sv
